// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master package
// Shared types, register indexes and reset values for the register-access
// I2C master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] CFG_PHASE_TICKS    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ACK_WAIT_LIMIT = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_END_GAP_TICKS  = 2'd2;

  localparam logic [CfgWidth-1:0] PHASE_TICKS_RST    = 16'd10;
  localparam logic [CfgWidth-1:0] ACK_WAIT_LIMIT_RST = 16'd5000;
  localparam logic [CfgWidth-1:0] END_GAP_TICKS_RST  = 16'd250;

  // Command kinds.
  localparam logic [1:0] KIND_WRITE_REG   = 2'd0;
  localparam logic [1:0] KIND_WRITE_NOREG = 2'd1;
  localparam logic [1:0] KIND_READ        = 2'd2;
  localparam logic [1:0] KIND_INVALID     = 2'd3;

  typedef struct packed {
    logic [CfgWidth-1:0] phase_ticks;
    logic [CfgWidth-1:0] ack_wait_limit;
    logic [CfgWidth-1:0] end_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] kind;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       ack_missing;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/i2cm_cmd_if.sv
// ----------------------------------------------------------------------------
// I2C master command channel
// Valid/ready channel carrying one tick of command and SDA input.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_cmd_if
  import i2cm_pkg::*;
  ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/i2cm_res_if.sv
// ----------------------------------------------------------------------------
// I2C master result channel
// Valid/ready channel carrying one tick of line levels and read status.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_res_if
  import i2cm_pkg::*;
  ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access
// Bit-level I2C master that performs register writes and reads, one command
// channel transaction per bus tick.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  cmd_i    in         command fields and sampled SDA, one transaction a tick
//  res_o    out        SCL/SDA drive, busy, read byte and ACK-missing flag
//  cfg_*    in         write-only registers: 0 phase_ticks, 1 ack_wait_limit,
//                      2 end_gap_ticks
//
// One command transaction is taken every cycle unless res_o stalls; its
// result is registered and offered on res_o in the following cycle.
// The sequencer's state update is a single pass of logic, so the rate is set
// only by how fast res_o drains its one-entry result register.
// When res_o stalls, cmd_i.ready drops until the held result is taken.
// Reset puts both lines in the released state with the sequencer idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_access
  import i2cm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  i2cm_cmd_if.sink                    cmd_i,
  i2cm_res_if.source                  res_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [CfgWidth-1:0]    cfg_wdata_i
);

  cfg_t cfg;
  res_t tick_res;
  logic slot_free;
  logic accept;

  assign cmd_i.ready = slot_free;
  assign accept      = cmd_i.valid && slot_free;

  i2cm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  i2cm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (accept),
    .cmd_i     (cmd_i.data),
    .res_o     (tick_res)
  );

  i2cm_res_reg u_res (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .res_i  (tick_res),
    .free_o (slot_free),
    .res_o  (res_o)
  );

  // A completed read byte always falls inside a running transfer.
  a_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.read_valid) |-> res_o.data.busy_res)
    else $error("read byte reported outside a transfer");

  // The last-byte mark only comes with a read byte.
  a_last_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.read_last) |-> res_o.data.read_valid)
    else $error("read_last without read_valid");

  // No command is taken while a stalled result still occupies the register.
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !cmd_i.ready)
    else $error("command accepted over a held result");

  // A taken command always yields a result in the next cycle.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> res_o.valid)
    else $error("accepted command produced no result");

endmodule

`default_nettype wire

// File: rtl/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// I2C master configuration registers
// Holds the line step hold, ACK wait limit and end gap length.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [CfgWidth-1:0]    cfg_wdata_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks    <= PHASE_TICKS_RST;
      cfg_q.ack_wait_limit <= ACK_WAIT_LIMIT_RST;
      cfg_q.end_gap_ticks  <= END_GAP_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_TICKS:    cfg_q.phase_ticks    <= cfg_wdata_i;
        CFG_ACK_WAIT_LIMIT: cfg_q.ack_wait_limit <= cfg_wdata_i;
        CFG_END_GAP_TICKS:  cfg_q.end_gap_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer
// Advances the bus program by one tick per accepted command item and forms
// the result of that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq
  import i2cm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic advance_i,
  input  wire cmd_t cmd_i,
  output res_t      res_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_WDEV, PH_WREG, PH_WDAT, PH_WDEVR, PH_ACK,
    PH_READS, PH_RBYTE, PH_MACK, PH_STOP, PH_GAP, PH_END
  } phase_e;

  // Segment sequence of each command kind.
  function automatic phase_e prog(input logic [1:0] kind, input logic [3:0] pc);
    phase_e code;
    code = PH_END;
    case (kind)
      KIND_WRITE_REG: begin
        case (pc)
          4'd0: code = PH_START;
          4'd1: code = PH_WDEV;
          4'd2: code = PH_ACK;
          4'd3: code = PH_WREG;
          4'd4: code = PH_ACK;
          4'd5: code = PH_WDAT;
          4'd6: code = PH_ACK;
          4'd7: code = PH_STOP;
          4'd8: code = PH_GAP;
          default: code = PH_END;
        endcase
      end
      KIND_WRITE_NOREG: begin
        case (pc)
          4'd0: code = PH_START;
          4'd1: code = PH_WDEV;
          4'd2: code = PH_ACK;
          4'd3: code = PH_WDAT;
          4'd4: code = PH_ACK;
          4'd5: code = PH_STOP;
          4'd6: code = PH_GAP;
          default: code = PH_END;
        endcase
      end
      KIND_READ: begin
        case (pc)
          4'd0: code = PH_START;
          4'd1: code = PH_WDEV;
          4'd2: code = PH_ACK;
          4'd3: code = PH_WREG;
          4'd4: code = PH_ACK;
          4'd5: code = PH_START;
          4'd6: code = PH_WDEVR;
          4'd7: code = PH_ACK;
          4'd8: code = PH_READS;
          4'd9: code = PH_STOP;
          4'd10: code = PH_GAP;
          default: code = PH_END;
        endcase
      end
      default: code = PH_END;
    endcase
    return code;
  endfunction

  function automatic logic [4:0] step_count(input phase_e ph);
    logic [4:0] n;
    case (ph)
      PH_START:                             n = 5'd4;
      PH_WDEV, PH_WREG, PH_WDAT, PH_WDEVR: n = 5'd26;
      PH_ACK:                               n = 5'd3;
      PH_RBYTE:                             n = 5'd18;
      PH_MACK:                              n = 5'd4;
      PH_STOP:                              n = 5'd3;
      default:                              n = 5'd1;
    endcase
    return n;
  endfunction

  phase_e      phase_q, phase_d;
  logic [4:0]  step_q, step_d;
  logic [15:0] timer_q, timer_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  left_q, left_d;
  logic [3:0]  pc_q, pc_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  wdat_q, wdat_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;

  logic        do_begin;
  logic        do_enter;
  logic        poll_ack;
  phase_e      code;
  logic [8:0]  prod11;
  logic [2:0]  quot3;
  logic [4:0]  rem3;
  logic [4:0]  step_inc;
  res_t        res;

  always_comb begin
    phase_d  = phase_q;
    step_d   = step_q;
    timer_d  = timer_q;
    shift_d  = shift_q;
    left_d   = left_q;
    pc_d     = pc_q;
    kind_d   = kind_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    wdat_d   = wdat_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    do_begin = 1'b0;
    do_enter = 1'b0;
    poll_ack = 1'b0;
    code     = PH_END;
    prod11   = '0;
    quot3    = '0;
    rem3     = '0;
    step_inc = '0;
    res      = '0;

    if (phase_q == PH_IDLE) begin
      if (cmd_i.cmd_valid && (cmd_i.kind != KIND_INVALID)) begin
        kind_d   = cmd_i.kind;
        dev_d    = cmd_i.device_address;
        reg_d    = cmd_i.register_address;
        wdat_d   = cmd_i.write_data;
        left_d   = cmd_i.read_count;
        pc_d     = '0;
        do_begin = 1'b1;
      end
    end else if ((phase_q == PH_ACK) && (step_q == 5'd1)) begin
      poll_ack = 1'b1;
    end else begin
      timer_d = timer_q - 16'd1;
      if (timer_d == '0) begin
        if ((phase_q == PH_ACK) && (step_q == 5'd0)) begin
          // The tick that ends the SCL-high hold is also the first poll.
          step_d   = 5'd1;
          timer_d  = '0;
          poll_ack = 1'b1;
        end else begin
          if ((phase_q == PH_RBYTE) && (step_q >= 5'd2) && !step_q[0]) begin
            shift_d = {shift_q[6:0], cmd_i.sda_in};
            if (step_q == 5'd16) begin
              left_d         = left_q - 8'd1;
              res.read_valid = 1'b1;
              res.read_data  = shift_d;
              res.read_last  = (left_d == '0);
            end
          end
          step_inc = step_q + 5'd1;
          step_d   = step_inc;
          if (step_inc >= step_count(phase_q)) begin
            step_d = '0;
            if (phase_q == PH_RBYTE) begin
              phase_d  = PH_MACK;
              do_enter = 1'b1;
            end else if ((phase_q == PH_MACK) && (left_d != '0)) begin
              phase_d  = PH_RBYTE;
              do_enter = 1'b1;
            end else begin
              pc_d     = pc_q + 4'd1;
              do_begin = 1'b1;
            end
          end else begin
            do_enter = 1'b1;
          end
        end
      end
    end

    if (poll_ack) begin
      if (cmd_i.sda_in) begin
        timer_d = timer_d + 16'd1;
        if (timer_d >= cfg_i.ack_wait_limit) begin
          res.ack_missing = 1'b1;
          step_d          = 5'd2;
          do_enter        = 1'b1;
        end
      end else begin
        step_d   = 5'd2;
        do_enter = 1'b1;
      end
    end

    if (do_begin) begin
      code = prog(kind_d, pc_d);
      // An empty read or a zero gap is skipped; what follows is never skipped.
      if (((code == PH_READS) && (left_d == '0)) ||
          ((code == PH_GAP) && (cfg_i.end_gap_ticks == '0))) begin
        pc_d = pc_d + 4'd1;
        code = prog(kind_d, pc_d);
      end
      step_d = '0;
      if (code == PH_END) begin
        phase_d = PH_IDLE;
        timer_d = '0;
      end else begin
        do_enter = 1'b1;
        if (code == PH_READS) begin
          phase_d = PH_RBYTE;
        end else begin
          phase_d = code;
          case (code)
            PH_WDEV:  shift_d = dev_d;
            PH_WREG:  shift_d = reg_d;
            PH_WDAT:  shift_d = wdat_d;
            PH_WDEVR: shift_d = dev_d + 8'd1;
            default: ;
          endcase
        end
      end
    end

    if (do_enter) begin
      timer_d = (cfg_i.phase_ticks != '0) ? cfg_i.phase_ticks : 16'd1;
      // Remainder of the step by three: quotient from a multiply by 11/32.
      prod11 = {4'b0, step_d} * 9'd11;
      quot3  = prod11[7:5];
      rem3   = step_d - 5'({2'b0, quot3} * 5'd3);
      case (phase_d)
        PH_START: begin
          case (step_d)
            5'd0:    sda_d = 1'b1;
            5'd1:    scl_d = 1'b1;
            5'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
        end
        PH_WDEV, PH_WREG, PH_WDAT, PH_WDEVR: begin
          if (step_d < 5'd24) begin
            if (rem3 == 5'd0) begin
              scl_d = 1'b0;
            end else if (rem3 == 5'd1) begin
              sda_d   = shift_d[7];
              shift_d = {shift_d[6:0], 1'b0};
            end else begin
              scl_d = 1'b1;
            end
          end else if (step_d == 5'd24) begin
            scl_d = 1'b0;
          end else begin
            sda_d = 1'b1;
          end
        end
        PH_ACK: begin
          if (step_d == 5'd0) begin
            scl_d = 1'b1;
          end else if (step_d == 5'd1) begin
            timer_d = '0;
          end else begin
            scl_d = 1'b0;
          end
        end
        PH_RBYTE: begin
          if (step_d == 5'd0) begin
            scl_d = 1'b0;
          end else if (step_d == 5'd1) begin
            sda_d = 1'b1;
          end else begin
            scl_d = !step_d[0];
          end
        end
        PH_MACK: begin
          if ((step_d == 5'd0) || (step_d == 5'd3)) begin
            scl_d = 1'b0;
          end else if (step_d == 5'd1) begin
            // ACK while more bytes follow, NACK on the last one.
            sda_d = (left_d == '0);
          end else begin
            scl_d = 1'b1;
          end
        end
        PH_STOP: begin
          case (step_d)
            5'd0:    sda_d = 1'b0;
            5'd1:    scl_d = 1'b1;
            default: sda_d = 1'b1;
          endcase
        end
        PH_GAP: timer_d = cfg_i.end_gap_ticks;
        default: ;
      endcase
    end

    res.scl_level = scl_d;
    res.sda_level = sda_d;
    res.busy_res  = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      timer_q <= '0;
      shift_q <= '0;
      left_q  <= '0;
      pc_q    <= '0;
      kind_q  <= '0;
      dev_q   <= '0;
      reg_q   <= '0;
      wdat_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (advance_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      pc_q    <= pc_d;
      kind_q  <= kind_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      wdat_q  <= wdat_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// File: rtl/i2cm_res_reg.sv
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one tick's result until the result channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_res_reg
  import i2cm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire res_t    res_i,
  output logic         free_o,
  i2cm_res_if.source   res_o
);

  logic valid_q;
  res_t data_q;

  // The slot can take a new result when empty or being emptied this cycle.
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.data  = data_q;

endmodule

`default_nettype wire
